[src/uvd_pkg.sv]
// ----------------------------------------------------------------------------
// uvd_pkg
// Shared types and constants for the unsigned LEB128 varint decoder.
// ----------------------------------------------------------------------------
package uvd_pkg;

  localparam int unsigned AccW  = 64;
  localparam int unsigned CntW  = 4;
  localparam int unsigned StatW = 3;

  // Index of the tenth byte of a value; its payload lands at bit 63.
  localparam logic [CntW-1:0] LAST_IDX = 4'd9;

  localparam logic [StatW-1:0] ST_OK            = 3'd0;
  localparam logic [StatW-1:0] ST_EMPTY         = 3'd1;
  localparam logic [StatW-1:0] ST_TOO_LONG      = 3'd2;
  localparam logic [StatW-1:0] ST_OVERFLOW      = 3'd3;
  localparam logic [StatW-1:0] ST_NON_CANONICAL = 3'd4;
  localparam logic [StatW-1:0] ST_UNTERMINATED  = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       buffer_end;
  } uvd_item_t;

  typedef struct packed {
    logic [AccW-1:0]  value;
    logic [StatW-1:0] status;
    logic [CntW-1:0]  consumed_count;
  } uvd_result_t;

endpackage

[src/unsigned_varint_decoder_unit.sv]
// ----------------------------------------------------------------------------
// unsigned_varint_decoder_unit
// Streaming decoder for unsigned 64-bit LEB128 varints, one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one beat per encoded byte (in_data_byte with
//   in_has_byte set) or an end-only marker (in_has_byte clear). in_buffer_end
//   flags the last beat of the available input. A beat that ends a value or
//   hits an error yields one result beat: value, status and consumed count.
//   Other beats yield nothing. cfg_wr_data sets canonical checking when
//   cfg_wr_en is high; write it only while the block is idle.
//   Throughput is one input beat per cycle unless a result waits on out_ready.
//   An accepted beat sits in the input register while the decode logic works
//   on it; once the result register has space, the accumulator is updated and
//   the result register is loaded, which raises out_valid for a result.
//   While a result waits on out_ready, one more beat is still accepted into
//   the input register; it holds there until the result register frees up.
//   Beats that produce no result drain under the same rule.
//   Reset empties both registers, clears the accumulator and byte count and
//   turns canonical checking off.
// ----------------------------------------------------------------------------
module unsigned_varint_decoder_unit
  import uvd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  input  logic             in_has_byte,
  input  logic             in_buffer_end,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [AccW-1:0]  out_value,
  output logic [StatW-1:0] out_status,
  output logic [CntW-1:0]  out_consumed_count
);

  logic        canonical_r;
  uvd_item_t   in_item;
  uvd_item_t   s1_item;
  logic        s1_valid;
  logic        space;
  logic        step;
  logic        res_valid;
  uvd_result_t res;
  uvd_result_t res_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canonical_r <= 1'b0;
    end else if (cfg_wr_en) begin
      canonical_r <= cfg_wr_data;
    end
  end

  assign in_item.data_byte  = in_data_byte;
  assign in_item.has_byte   = in_has_byte;
  assign in_item.buffer_end = in_buffer_end;

  assign step = s1_valid && space;

  uvd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (step),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  uvd_decode u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .canonical (canonical_r),
    .step      (step),
    .item      (s1_item),
    .res_valid (res_valid),
    .res       (res)
  );

  uvd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_valid),
    .res_in    (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_out)
  );

  assign out_value          = res_out.value;
  assign out_status         = res_out.status;
  assign out_consumed_count = res_out.consumed_count;

`ifndef SYNTH
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without a full pipeline");

  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !space) |=> (s1_valid && $stable(s1_item)))
    else $error("pending beat lost while the result register is full");
`endif

endmodule

[src/uvd_in_stage.sv]
// ----------------------------------------------------------------------------
// uvd_in_stage
// Input register: holds one accepted beat until the decode stage takes it.
// ----------------------------------------------------------------------------
module uvd_in_stage
  import uvd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  uvd_item_t in_item,
  input  logic      take,
  output logic      s1_valid,
  output uvd_item_t s1_item
);

  logic      valid_r;
  logic      valid_nxt;
  uvd_item_t item_r;

  // A new beat may enter when the register is empty or drains this cycle.
  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

[src/uvd_decode.sv]
// ----------------------------------------------------------------------------
// uvd_decode
// Accumulator, byte count and the per-byte decode logic.
// ----------------------------------------------------------------------------
module uvd_decode
  import uvd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        canonical,
  input  logic        step,
  input  uvd_item_t   item,
  output logic        res_valid,
  output uvd_result_t res
);

  logic [AccW-1:0] acc_r;
  logic [AccW-1:0] acc_nxt;
  logic [CntW-1:0] cnt_r;
  logic [CntW-1:0] cnt_nxt;

  logic [6:0]      chunk;
  logic [5:0]      shift;
  logic [AccW-1:0] acc_or;
  logic [CntW-1:0] taken;
  logic            at_last;

  assign chunk   = item.data_byte[6:0];
  assign shift   = 6'({2'b00, cnt_r} * 6'd7);
  assign acc_or  = acc_r | (AccW'(chunk) << shift);
  assign taken   = cnt_r + 4'd1;
  assign at_last = (cnt_r == LAST_IDX);

  always_comb begin
    res_valid = 1'b0;
    res.value = '0;
    res.status = ST_OK;
    res.consumed_count = '0;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    if (!item.has_byte) begin
      if (item.buffer_end) begin
        res_valid = 1'b1;
        res.status = (cnt_r == '0) ? ST_EMPTY : ST_UNTERMINATED;
        res.consumed_count = cnt_r;
      end
    end else if (at_last && (chunk > 7'd1)) begin
      // The tenth byte only has room for bit 63.
      res_valid = 1'b1;
      res.status = ST_OVERFLOW;
      res.consumed_count = cnt_r;
    end else if (!item.data_byte[7]) begin
      res_valid = 1'b1;
      res.consumed_count = taken;
      // A multi-byte value is minimal exactly when its last chunk is nonzero.
      if (canonical && (cnt_r != '0) && (chunk == '0)) begin
        res.status = ST_NON_CANONICAL;
      end else begin
        res.value = acc_or;
      end
    end else if (at_last) begin
      res_valid = 1'b1;
      res.status = ST_TOO_LONG;
      res.consumed_count = taken;
    end else if (item.buffer_end) begin
      res_valid = 1'b1;
      res.status = ST_UNTERMINATED;
      res.consumed_count = taken;
    end else begin
      acc_nxt = acc_or;
      cnt_nxt = taken;
    end
    if (res_valid) begin
      acc_nxt = '0;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else if (step) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST_IDX)
    else $error("byte count beyond the tenth byte");

  a_open_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (acc_r == '0))
    else $error("accumulator holds bits with no open value");
`endif

endmodule

[src/uvd_out_stage.sv]
// ----------------------------------------------------------------------------
// uvd_out_stage
// Result register toward the output channel.
// ----------------------------------------------------------------------------
module uvd_out_stage
  import uvd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  uvd_result_t res_in,
  output logic        space,
  output logic        out_valid,
  input  logic        out_ready,
  output uvd_result_t res_out
);

  logic        valid_r;
  logic        valid_nxt;
  uvd_result_t res_r;

  assign space     = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

`ifndef SYNTH
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (res_r.status != ST_OK)) |-> (res_r.value == '0))
    else $error("error result carries a nonzero value");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (res_r.consumed_count <= 4'd10))
    else $error("consumed count above ten");
`endif

endmodule
